// File: rtl/slir_pkg.sv
`timescale 1ns / 1ps

package slir_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int VAL_W     = 32;
    localparam int POS_W     = 6;
    localparam int CNT_W     = 7;
    localparam int ST_W      = 2;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic                    operation;
        logic signed [VAL_W-1:0] value;
        logic        [POS_W-1:0] position;
    } t_slir_in;

    typedef struct packed {
        logic signed [VAL_W-1:0] removed_value;
        logic        [CNT_W-1:0] entry_count;
        logic        [ST_W-1:0]  status;
    } t_slir_out;

    // broadcast from the top level to every cell
    typedef struct packed {
        logic                    en;
        logic                    ins;
        logic signed [VAL_W-1:0] value;
    } t_slir_ctl;

    // per-cell position flags, derived from count and position
    typedef struct packed {
        logic occupied;
        logic at_count;
        logic from_pos;
    } t_slir_loc;

endpackage

// File: rtl/slir_cell.sv
`timescale 1ns / 1ps

module slir_cell
    import slir_pkg::*;
(
    input  logic                    i_clk,
    input  t_slir_ctl               i_ctl,
    input  t_slir_loc               i_loc,
    input  logic signed [VAL_W-1:0] i_left_val,
    input  logic                    i_left_ge,
    input  logic signed [VAL_W-1:0] i_right_val,
    output logic signed [VAL_W-1:0] o_val,
    output logic                    o_ge
);

    logic signed [VAL_W-1:0] r_val;
    logic signed [VAL_W-1:0] n_val;

    // occupied entry holds a value not below the broadcast one
    assign o_ge  = i_loc.occupied && !(r_val < i_ctl.value);
    assign o_val = r_val;

    always_comb begin
        n_val = r_val;
        if (i_ctl.en) begin
            if (i_ctl.ins) begin
                if (i_left_ge) begin
                    n_val = i_left_val;
                end else if (o_ge || i_loc.at_count) begin
                    n_val = i_ctl.value;
                end
            end else if (i_loc.from_pos) begin
                n_val = i_right_val;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule

// File: rtl/sorted_list_insert_remove.sv
`timescale 1ns / 1ps

// Sorted list of up to DEPTH signed 32-bit values, kept in ascending order
// in a row of cells, one value per cell. A word is taken when start is high
// and busy is low; an insert puts its value ahead of all equal entries, a
// removal takes out the entry at the given position. Every word gives one
// result, shown on o_result for exactly one cycle with o_strobe high, in the
// cycle after the word was taken; the receiver cannot hold it off. Busy is
// high only during reset and the cycle after it, so a new word may follow
// in every cycle: all cells compare against the broadcast value and shift
// toward their neighbors in the same clock, and the next word sees the
// updated row. A full list on insert (status 1) or a position not below the
// count on removal (status 2) leaves the list as it was. Cells at or above
// the count hold no meaningful data and need no clearing after reset.
module sorted_list_insert_remove
    import slir_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_slir_in  i_item,
    output logic      o_strobe,
    output t_slir_out o_result
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = (CW > POS_W) ? CW : POS_W;

    logic             r_busy;
    logic             r_strobe;
    t_slir_out        r_result;
    logic [CW-1:0]    r_count;
    logic [CW-1:0]    n_count;

    logic             accept;
    logic             ins;
    logic             full;
    logic             range_err;
    logic             ok;
    logic [IW-1:0]    pos_x;
    logic [IW-1:0]    cnt_x;
    logic signed [VAL_W-1:0] sel_val;

    t_slir_ctl        ctl;
    logic signed [VAL_W-1:0] w_val [DEPTH];
    logic             w_ge  [DEPTH];

    assign busy     = r_busy;
    assign o_strobe = r_strobe;
    assign o_result = r_result;

    assign accept    = start && !r_busy;
    assign ins       = (i_item.operation == OP_INSERT);
    assign pos_x     = IW'(i_item.position);
    assign cnt_x     = IW'(r_count);
    assign full      = (r_count == CW'(DEPTH));
    assign range_err = (pos_x >= cnt_x);
    assign ok        = accept && (ins ? !full : !range_err);

    assign ctl.en    = ok;
    assign ctl.ins   = ins;
    assign ctl.value = i_item.value;

    // grow or shrink the count by one on a successful word
    always_comb begin
        n_count = r_count;
        if (ok) begin
            if (ins) begin
                n_count = CW'(r_count + 1'b1);
            end else begin
                n_count = CW'(r_count - 1'b1);
            end
        end
    end

    // pick the entry at the removal position
    always_comb begin
        sel_val = '0;
        for (int k = 0; k < DEPTH; k++) begin
            if (IW'(k) == pos_x) begin
                sel_val = w_val[k];
            end
        end
    end

    // row of cells: insert shifts up from the insertion point,
    // removal shifts down from the removal position
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_slir_loc               loc;
        logic signed [VAL_W-1:0] left_val;
        logic                    left_ge;
        logic signed [VAL_W-1:0] right_val;

        assign loc.occupied = (CW'(g) < r_count);
        assign loc.at_count = (CW'(g) == r_count);
        assign loc.from_pos = (IW'(g) >= pos_x);

        if (g == 0) begin : g_first
            assign left_val = '0;
            assign left_ge  = 1'b0;
        end else begin : g_mid
            assign left_val = w_val[g-1];
            assign left_ge  = w_ge[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign right_val = w_val[g];
        end else begin : g_inner
            assign right_val = w_val[g+1];
        end

        slir_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (ctl),
            .i_loc       (loc),
            .i_left_val  (left_val),
            .i_left_ge   (left_ge),
            .i_right_val (right_val),
            .o_val       (w_val[g]),
            .o_ge        (w_ge[g])
        );
    end

    // control: hold busy through reset, count and strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b1;
            r_strobe <= 1'b0;
            r_count  <= '0;
        end else begin
            r_busy   <= 1'b0;
            r_strobe <= accept;
            r_count  <= n_count;
        end
    end

    // result word, loaded on every accepted word
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_result.entry_count <= CNT_W'(n_count);
            if (ins) begin
                r_result.removed_value <= '0;
                r_result.status        <= full ? ST_FULL : ST_DONE;
            end else begin
                r_result.removed_value <= range_err ? '0 : sel_val;
                r_result.status        <= range_err ? ST_RANGE : ST_DONE;
            end
        end
    end

endmodule

// File: rtl/slir_chk.sv
`timescale 1ns / 1ps

module slir_chk
    import slir_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      start,
    input logic      busy,
    input t_slir_in  i_item,
    input logic      o_strobe,
    input t_slir_out o_result
);

    // each taken word gives exactly one result in the next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> o_strobe)
        else $error("no result after a taken word");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(start && !busy) |=> !o_strobe)
        else $error("result without a taken word");

    // rejected words report no removed value
    a_zero_removed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_result.status == ST_FULL || o_result.status == ST_RANGE))
        |-> (o_result.removed_value == '0))
        else $error("removed value on a rejected word");

    // full status only when the list is at capacity
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.status == ST_FULL)
        |-> (o_result.entry_count == CNT_W'(DEPTH)))
        else $error("full status below capacity");

    // back-to-back results move the count by at most one
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && $past(o_strobe))
        |-> (o_result.entry_count == $past(o_result.entry_count)
             || o_result.entry_count == CNT_W'($past(o_result.entry_count) + 1'b1)
             || o_result.entry_count == CNT_W'($past(o_result.entry_count) - 1'b1)))
        else $error("count jumped by more than one");

endmodule

bind sorted_list_insert_remove slir_chk #(.DEPTH(DEPTH)) u_slir_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_item   (i_item),
    .o_strobe (o_strobe),
    .o_result (o_result)
);

// File: sim/tb_sorted_list_insert_remove.sv
`timescale 1ns / 1ps

module tb_sorted_list_insert_remove;
    import slir_pkg::*;

    localparam int LIST_DEPTH  = DEPTH_DEF;
    // longest legal quiet stretch is an idle burst plus reset
    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_CYCLES = 8;

    localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
    localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start   = 1'b0;
    logic      busy;
    t_slir_in  i_item  = '0;
    logic      o_strobe;
    t_slir_out o_result;

    // shadow copy of the list contents, updated when a word is taken
    logic signed [VAL_W-1:0] shadow_list[$];
    // results still owed by the block, oldest first
    t_slir_out               awaited_results[$];

    bit idle_en;
    int err_cnt   = 0;
    int stall_cnt = 0;
    // entry count as the sender sees it, to steer positions and ops
    int list_fill = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    sorted_list_insert_remove #(
        .DEPTH(LIST_DEPTH)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_item  (i_item),
        .o_strobe(o_strobe),
        .o_result(o_result)
    );

    // Apply one word to the shadow list and return the result it must give.
    // Insert goes ahead of equal entries: scan past strictly smaller ones only.
    function automatic t_slir_out apply_list_word(t_slir_in w);
        t_slir_out r;
        int        at;
        r = '0;
        if (w.operation == OP_INSERT) begin
            if (shadow_list.size() >= LIST_DEPTH) begin
                r.status = ST_FULL;
            end else begin
                at = 0;
                while (at < shadow_list.size() &&
                       $signed(shadow_list[at]) < $signed(w.value))
                    at++;
                shadow_list.insert(at, w.value);
            end
        end else begin
            if (int'(w.position) >= shadow_list.size()) begin
                r.status = ST_RANGE;
            end else begin
                r.removed_value = shadow_list[w.position];
                shadow_list.delete(int'(w.position));
            end
        end
        r.entry_count = CNT_W'(shadow_list.size());
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] exp_v,
                                   input logic [63:0] got_v);
        $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, what, exp_v, got_v);
        err_cnt++;
    endtask

    // Check first, then record the new word: the strobe seen at this edge
    // always belongs to a word taken at an earlier edge.
    always @(posedge i_clk) begin
        t_slir_out exp_r;
        if (i_rst_n) begin
            if (o_strobe === 1'b1) begin
                if (awaited_results.size() == 0) begin
                    report_mismatch("unexpected result", 64'd0, 64'(o_result));
                end else begin
                    exp_r = awaited_results.pop_front();
                    if (o_result.removed_value !== exp_r.removed_value)
                        report_mismatch("removed_value", 64'(exp_r.removed_value),
                                        64'(o_result.removed_value));
                    if (o_result.entry_count !== exp_r.entry_count)
                        report_mismatch("entry_count", 64'(exp_r.entry_count),
                                        64'(o_result.entry_count));
                    if (o_result.status !== exp_r.status)
                        report_mismatch("status", 64'(exp_r.status), 64'(o_result.status));
                end
            end else if (o_strobe !== 1'b0) begin
                report_mismatch("strobe level", 64'd0, 64'(o_strobe));
            end
            if (start && busy === 1'b0)
                awaited_results.insert(awaited_results.size(), apply_list_word(i_item));
        end
    end

    // Watchdog: end the run when nothing moves for too long.
    always @(posedge i_clk) begin
        if ((start && busy === 1'b0) || o_strobe === 1'b1)
            stall_cnt <= 0;
        else
            stall_cnt <= stall_cnt + 1;
        if (stall_cnt >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Hold start high with the word until an edge where busy is low.
    // Start is only lowered here for an idle burst, so back-to-back words
    // keep it high without a glitch.
    task automatic send_word(input logic op, input logic signed [VAL_W-1:0] val,
                             input logic [POS_W-1:0] pos);
        t_slir_in w;
        w.operation = op;
        w.value     = val;
        w.position  = pos;
        if (idle_en && $urandom_range(0, 4) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= w;
        do @(posedge i_clk); while (busy !== 1'b0);
        if (op == OP_INSERT) begin
            if (list_fill < LIST_DEPTH)
                list_fill++;
        end else if (int'(pos) < list_fill) begin
            list_fill--;
        end
    endtask

    // Drop start and hold off until every owed result has come back.
    task automatic wait_until_drained();
        start <= 1'b0;
        do @(posedge i_clk); while (awaited_results.size() != 0);
    endtask

    // Mix of extremes, small values that collide often, and full-range values.
    function automatic logic signed [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return VAL_MIN;
            1:       return VAL_MAX;
            2, 3, 4: return VAL_W'(int'($urandom_range(0, 16)) - 8);
            default: return VAL_W'($urandom());
        endcase
    endfunction

    // Mostly a valid position, sometimes anything the field allows.
    function automatic logic [POS_W-1:0] pick_position();
        if (list_fill > 0 && $urandom_range(0, 99) < 85)
            return POS_W'($urandom_range(0, list_fill - 1));
        return POS_W'($urandom_range(0, (1 << POS_W) - 1));
    endfunction

    task automatic send_random_word(input int insert_pct);
        if ($urandom_range(0, 99) < insert_pct)
            send_word(OP_INSERT, pick_value(), POS_W'($urandom()));
        else
            send_word(OP_REMOVE, VAL_W'($urandom()), pick_position());
    endtask

    task automatic do_reset();
        i_rst_n <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
    endtask

    // Empty-list removals, value extremes, duplicates, first/last removal,
    // removal at and past the count.
    task automatic test_directed();
        idle_en = 1'b0;
        send_word(OP_REMOVE, 32'sd0, 6'd0);
        send_word(OP_REMOVE, VAL_MAX, 6'd63);
        send_word(OP_INSERT, 32'sd0, 6'd63);
        send_word(OP_INSERT, VAL_MAX, 6'd0);
        send_word(OP_INSERT, VAL_MIN, 6'd0);
        send_word(OP_INSERT, -32'sd1, 6'd0);
        send_word(OP_INSERT, 32'sd1, 6'd0);
        send_word(OP_INSERT, 32'sd0, 6'd0);
        send_word(OP_INSERT, VAL_MAX, 6'd0);
        send_word(OP_INSERT, VAL_MIN, 6'd0);
        send_word(OP_REMOVE, 32'sd0, 6'd0);
        send_word(OP_REMOVE, 32'sd0, 6'd6);
        send_word(OP_REMOVE, 32'sd0, 6'd6);
        send_word(OP_REMOVE, 32'sd0, 6'd63);
        send_word(OP_REMOVE, 32'sd0, 6'd2);
        send_word(OP_INSERT, -32'sd5, 6'd0);
        send_word(OP_INSERT, -32'sd5, 6'd0);
        send_word(OP_REMOVE, VAL_MIN, 6'd1);
        send_word(OP_REMOVE, 32'sd0, 6'd5);
        send_word(OP_REMOVE, 32'sd0, 6'd4);
        wait_until_drained();
    endtask

    // Fill to the limit, bounce off the full list, then drain to empty.
    task automatic test_fill_and_drain(input int rounds);
        for (int r = 0; r < rounds; r++) begin
            idle_en = r[0];
            while (list_fill < LIST_DEPTH)
                send_word(OP_INSERT, pick_value(), POS_W'($urandom()));
            repeat (3) send_word(OP_INSERT, pick_value(), POS_W'($urandom()));
            send_word(OP_REMOVE, 32'sd0, 6'd63);
            if (r == 0)
                wait_until_drained();
            while (list_fill > 0)
                send_random_word(0);
            send_word(OP_REMOVE, VAL_W'($urandom()), POS_W'($urandom()));
        end
    endtask

    // Random walk with phases biased up and down so the count sweeps its range.
    task automatic test_random_mix(input int n_words);
        for (int i = 0; i < n_words; i++) begin
            idle_en = ((i / 200) % 2) == 0;
            if (i % 300 == 150)
                wait_until_drained();
            send_random_word(((i / 100) % 2) == 0 ? 70 : 30);
        end
    endtask

    // Closing stretch: a new word every cycle, no idling.
    task automatic test_back_to_back(input int n_words);
        idle_en = 1'b0;
        for (int i = 0; i < n_words; i++)
            send_random_word(list_fill < 4 ? 80 : (list_fill > 60 ? 30 : 55));
    endtask

    initial begin
        do_reset();
        test_directed();
        test_fill_and_drain(3);
        test_random_mix(1200);
        test_back_to_back(400);
        wait_until_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
